// ===== rtl/core/vtrh_pkg.sv =====
package vtrh_pkg;

  // Default sizes of the internal state
  localparam int TEMP_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 8;

  // Fixed field widths
  localparam int SAMPLE_BITS    = 12;
  localparam int LIMIT_BITS     = 12;
  localparam int AFTER_BITS     = 8;
  localparam int STATUS_BITS    = 3;

  // Register port
  localparam int APB_DATA_BITS  = 32;
  localparam int APB_ADDR_BITS  = 5;
  localparam int REG_IDX_BITS   = 3;

  // Reset values
  localparam int LAST_GOOD_RESET = -16;    // minus one degree
  localparam logic [LIMIT_BITS-1:0] LOW_LIMIT_RESET  = 12'd0;
  localparam logic [LIMIT_BITS-1:0] HIGH_LIMIT_RESET = 12'd1600;
  localparam logic [LIMIT_BITS-1:0] MAX_STEP_RESET   = 12'd160;
  localparam logic [AFTER_BITS-1:0] ERR_AFTER_RESET  = 8'd3;
  localparam logic [LIMIT_BITS-1:0] ON_LEVEL_RESET   = 12'd960;
  localparam logic [LIMIT_BITS-1:0] OFF_LEVEL_RESET  = 12'd800;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_LOW_LIMIT  = 3'd0,
    REG_HIGH_LIMIT = 3'd1,
    REG_MAX_STEP   = 3'd2,
    REG_ERR_AFTER  = 3'd3,
    REG_ON_LEVEL   = 3'd4,
    REG_OFF_LEVEL  = 3'd5
  } reg_idx_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SENSOR = 3'd1,
    ST_TOO_LOW   = 3'd2,
    ST_TOO_HIGH  = 3'd3,
    ST_STEP      = 3'd4
  } status_t;

  // Configuration as seen by the datapath (limits and levels are signed)
  typedef struct packed {
    logic [LIMIT_BITS-1:0] low_limit;
    logic [LIMIT_BITS-1:0] high_limit;
    logic [LIMIT_BITS-1:0] max_step;
    logic [AFTER_BITS-1:0] error_after;
    logic [LIMIT_BITS-1:0] relay_on_level;
    logic [LIMIT_BITS-1:0] relay_off_level;
  } cfg_t;

endpackage

// ===== rtl/core/vtrh_cfg.sv =====
module vtrh_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vtrh_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [vtrh_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [vtrh_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output vtrh_pkg::cfg_t                     cfg
);

  vtrh_pkg::cfg_t   cfg_r;
  vtrh_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = vtrh_pkg::reg_idx_t'(paddr[vtrh_pkg::APB_ADDR_BITS-1:2]);
  assign cfg    = cfg_r;

  // Register writes on the access phase; unmapped addresses are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_limit       <= vtrh_pkg::LOW_LIMIT_RESET;
      cfg_r.high_limit      <= vtrh_pkg::HIGH_LIMIT_RESET;
      cfg_r.max_step        <= vtrh_pkg::MAX_STEP_RESET;
      cfg_r.error_after     <= vtrh_pkg::ERR_AFTER_RESET;
      cfg_r.relay_on_level  <= vtrh_pkg::ON_LEVEL_RESET;
      cfg_r.relay_off_level <= vtrh_pkg::OFF_LEVEL_RESET;
    end else if (wr_en) begin
      case (idx)
        vtrh_pkg::REG_LOW_LIMIT:  cfg_r.low_limit   <= pwdata[vtrh_pkg::LIMIT_BITS-1:0];
        vtrh_pkg::REG_HIGH_LIMIT: cfg_r.high_limit  <= pwdata[vtrh_pkg::LIMIT_BITS-1:0];
        vtrh_pkg::REG_MAX_STEP:   cfg_r.max_step    <= pwdata[vtrh_pkg::LIMIT_BITS-1:0];
        vtrh_pkg::REG_ERR_AFTER:  cfg_r.error_after <= pwdata[vtrh_pkg::AFTER_BITS-1:0];
        vtrh_pkg::REG_ON_LEVEL:   cfg_r.relay_on_level  <= pwdata[vtrh_pkg::LIMIT_BITS-1:0];
        vtrh_pkg::REG_OFF_LEVEL:  cfg_r.relay_off_level <= pwdata[vtrh_pkg::LIMIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    prdata = '0;
    case (idx)
      vtrh_pkg::REG_LOW_LIMIT:  prdata = vtrh_pkg::APB_DATA_BITS'(cfg_r.low_limit);
      vtrh_pkg::REG_HIGH_LIMIT: prdata = vtrh_pkg::APB_DATA_BITS'(cfg_r.high_limit);
      vtrh_pkg::REG_MAX_STEP:   prdata = vtrh_pkg::APB_DATA_BITS'(cfg_r.max_step);
      vtrh_pkg::REG_ERR_AFTER:  prdata = vtrh_pkg::APB_DATA_BITS'(cfg_r.error_after);
      vtrh_pkg::REG_ON_LEVEL:   prdata = vtrh_pkg::APB_DATA_BITS'(cfg_r.relay_on_level);
      vtrh_pkg::REG_OFF_LEVEL:  prdata = vtrh_pkg::APB_DATA_BITS'(cfg_r.relay_off_level);
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/validated_temp_relay_hysteresis.sv =====
// Thermostat relay with a plausibility check on every reading. Each input transfer
// carries a sensor-present flag and a signed temperature in 1/16 degree C; each
// produces exactly one result transfer with a status code, the relay state and the
// last accepted temperature. A reading is held in an input register, checked and
// applied to the state in one short combinational pass, and lands in a result
// register; one reading is taken every cycle while the result side does not stall,
// and the result register lets the next reading enter while a result waits to be taken.
// Thresholds, limits, the step bound and the error count are set through an APB
// port with no wait states, register i at byte address 4*i, and are to be written
// only while no reading is in flight.
module validated_temp_relay_hysteresis #(
  parameter int TEMP_BITS  = vtrh_pkg::TEMP_BITS_DEF,
  parameter int COUNT_BITS = vtrh_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [vtrh_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [vtrh_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [vtrh_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  // readings
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_sensor_present,
  input  logic [vtrh_pkg::SAMPLE_BITS-1:0]     in_sample_temperature,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [vtrh_pkg::STATUS_BITS-1:0]     out_status,
  output logic                                 out_relay_on,
  output logic [vtrh_pkg::SAMPLE_BITS-1:0]     out_last_good_temperature
);

  localparam int DIFF_BITS = TEMP_BITS + 2;
  localparam int CMP_BITS  = (COUNT_BITS > vtrh_pkg::AFTER_BITS) ?
                             COUNT_BITS : vtrh_pkg::AFTER_BITS;

  vtrh_pkg::cfg_t cfg;

  // Input stage
  logic                              in_vld_r;
  logic                              in_present_r;
  logic [vtrh_pkg::SAMPLE_BITS-1:0]  in_temp_r;

  // State
  logic signed [TEMP_BITS-1:0]       last_good_r, last_good_nxt;
  logic                              have_good_r, have_good_nxt;
  logic [COUNT_BITS-1:0]             reject_cnt_r, reject_cnt_nxt;
  logic                              relay_r, relay_nxt;

  // Result stage
  logic                              out_vld_r;
  logic [vtrh_pkg::STATUS_BITS-1:0]  out_status_r;
  logic                              out_relay_r;
  logic [vtrh_pkg::SAMPLE_BITS-1:0]  out_temp_r;

  // Evaluation
  logic                              advance;
  logic signed [DIFF_BITS-1:0]       temp_ext, last_ext, diff, step_ext;
  logic                              step_bad;
  vtrh_pkg::status_t                 err;
  vtrh_pkg::status_t                 status;
  logic                              report;
  logic signed [TEMP_BITS-1:0]       on_ext, off_ext;

  vtrh_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline flow
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // Plausibility checks, first match wins
  always_comb begin
    temp_ext = DIFF_BITS'($signed(in_temp_r));
    last_ext = DIFF_BITS'(last_good_r);
    diff     = temp_ext - last_ext;
    step_ext = DIFF_BITS'($signed({1'b0, cfg.max_step}));
    step_bad = have_good_r && ((diff > step_ext) || (diff < -step_ext));

    if (!in_present_r) begin
      err = vtrh_pkg::ST_NO_SENSOR;
    end else if ($signed(in_temp_r) <= $signed(cfg.low_limit)) begin
      err = vtrh_pkg::ST_TOO_LOW;
    end else if ($signed(in_temp_r) >= $signed(cfg.high_limit)) begin
      err = vtrh_pkg::ST_TOO_HIGH;
    end else if (step_bad) begin
      err = vtrh_pkg::ST_STEP;
    end else begin
      err = vtrh_pkg::ST_OK;
    end
  end

  // Counter, stored reading and relay hysteresis
  always_comb begin
    on_ext  = TEMP_BITS'($signed(cfg.relay_on_level));
    off_ext = TEMP_BITS'($signed(cfg.relay_off_level));

    if (err != vtrh_pkg::ST_OK) begin
      reject_cnt_nxt = (reject_cnt_r == '1) ? reject_cnt_r : reject_cnt_r + 1'b1;
      last_good_nxt  = last_good_r;
      have_good_nxt  = have_good_r;
    end else begin
      reject_cnt_nxt = '0;
      last_good_nxt  = TEMP_BITS'($signed(in_temp_r));
      have_good_nxt  = 1'b1;
    end

    report = (err != vtrh_pkg::ST_OK) &&
             (CMP_BITS'(reject_cnt_nxt) >= CMP_BITS'(cfg.error_after));
    status = report ? err : vtrh_pkg::ST_OK;

    relay_nxt = relay_r;
    if (!report) begin
      if (last_good_nxt >= on_ext) begin
        relay_nxt = 1'b1;
      end else if (last_good_nxt <= off_ext) begin
        relay_nxt = 1'b0;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_present_r <= in_sensor_present;
      in_temp_r    <= in_sample_temperature;
    end
  end

  // State update as a reading moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_good_r  <= TEMP_BITS'(vtrh_pkg::LAST_GOOD_RESET);
      have_good_r  <= 1'b0;
      reject_cnt_r <= '0;
      relay_r      <= 1'b0;
    end else if (advance) begin
      last_good_r  <= last_good_nxt;
      have_good_r  <= have_good_nxt;
      reject_cnt_r <= reject_cnt_nxt;
      relay_r      <= relay_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= status;
      out_relay_r  <= relay_nxt;
      out_temp_r   <= last_good_nxt[vtrh_pkg::SAMPLE_BITS-1:0];
    end
  end

  assign out_valid                 = out_vld_r;
  assign out_status                = out_status_r;
  assign out_relay_on              = out_relay_r;
  assign out_last_good_temperature = out_temp_r;

endmodule
